// File: rtl/core/gccd_pkg.sv
// ----------------------------------------------------------------------------
// gccd_pkg
// Shared types and constants of the Gray code column decoder: register map,
// reset values, sample kinds and the configuration bundle.
// ----------------------------------------------------------------------------
package gccd_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [4:0] MaxPatterns = 5'd16;

  typedef enum logic [1:0] {
    RegThreshold = 2'd0,
    RegPatterns  = 2'd1,
    RegShift     = 2'd2,
    RegColCount  = 2'd3
  } reg_idx_e;

  typedef enum logic {
    ReqReference = 1'b0,
    ReqPattern   = 1'b1
  } req_e;

  localparam logic [7:0]  ResetThreshold = 8'd32;
  localparam logic [4:0]  ResetPatterns  = 5'd10;
  localparam logic [15:0] ResetShift     = 16'd0;
  localparam logic [16:0] ResetColCount  = 17'd1024;

  typedef struct packed {
    logic [7:0]  contrast_threshold;
    logic [4:0]  pattern_count;
    logic [15:0] column_shift;
    logic [16:0] column_count;
  } cfg_t;

endpackage

// File: rtl/core/gccd_cfg.sv
// ----------------------------------------------------------------------------
// gccd_cfg
// APB register file of the decoder: threshold, pattern count, column shift
// and column count, readable and writable, always ready.
// ----------------------------------------------------------------------------
module gccd_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gccd_pkg::AddrWidth-1:0]      paddr,
  input  logic [gccd_pkg::DataWidth-1:0]      pwdata,
  output logic [gccd_pkg::DataWidth-1:0]      prdata,
  output logic                                pready,
  output gccd_pkg::cfg_t                      cfg_o
);

  gccd_pkg::cfg_t     cfg_q;
  gccd_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = gccd_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.contrast_threshold <= gccd_pkg::ResetThreshold;
      cfg_q.pattern_count      <= gccd_pkg::ResetPatterns;
      cfg_q.column_shift       <= gccd_pkg::ResetShift;
      cfg_q.column_count       <= gccd_pkg::ResetColCount;
    end else if (wr_en) begin
      case (idx)
        gccd_pkg::RegThreshold: cfg_q.contrast_threshold <= pwdata[7:0];
        gccd_pkg::RegPatterns:  cfg_q.pattern_count      <= pwdata[4:0];
        gccd_pkg::RegShift:     cfg_q.column_shift       <= pwdata[15:0];
        gccd_pkg::RegColCount:  cfg_q.column_count       <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      gccd_pkg::RegThreshold: prdata = {24'd0, cfg_q.contrast_threshold};
      gccd_pkg::RegPatterns:  prdata = {27'd0, cfg_q.pattern_count};
      gccd_pkg::RegShift:     prdata = {16'd0, cfg_q.column_shift};
      gccd_pkg::RegColCount:  prdata = {15'd0, cfg_q.column_count};
      default:                prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/gray_code_column_decoder.sv
// ----------------------------------------------------------------------------
// gray_code_column_decoder
// Structured-light decoder: a reference pair sets the pixel mask, then Gray
// code pairs are thresholded, converted to binary and summed into a column.
// ----------------------------------------------------------------------------
//  channel  | signals                                         | direction
//  ---------+-------------------------------------------------+----------
//  input    | in_valid_i/in_ready_o, req_type_i, first_sample_i,
//           | second_sample_i, prior_mask_i                   | in
//  output   | out_valid_o/out_ready_i, decoded_column_o,
//           | column_valid_o                                  | out
//  config   | psel, penable, pwrite, paddr, pwdata, prdata, pready | apb
//
// one transaction per cycle sustained while the output is not stalled; a
// sample pair passes an input register and one compare/add/subtract stage
// into the result register. reset clears pixel state and loads register
// defaults. a stalled result holds only the input register; the next pair is
// taken as soon as the result register is drained.
// ----------------------------------------------------------------------------
module gray_code_column_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [7:0]                     first_sample_i,
  input  logic [7:0]                     second_sample_i,
  input  logic                           prior_mask_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [15:0]                    decoded_column_o,
  output logic                           column_valid_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gccd_pkg::AddrWidth-1:0] paddr,
  input  logic [gccd_pkg::DataWidth-1:0] pwdata,
  output logic [gccd_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);

  gccd_pkg::cfg_t cfg;

  gccd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  logic       in_valid_q;
  logic       req_type_q;
  logic [7:0] first_q;
  logic [7:0] second_q;
  logic       prior_q;

  // pixel state
  logic        lit_mask_q, lit_mask_d;
  logic        parity_q, parity_d;
  logic [4:0]  pos_q, pos_d;
  logic [15:0] sum_q, sum_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [15:0] col_q, col_d;
  logic        cval_q, cval_d;

  logic        advance;
  logic        fire;
  logic        emit;
  logic [4:0]  n_eff;
  logic [7:0]  diff;
  logic        bit_ge;
  logic        par_new;
  logic [4:0]  pos_new;
  logic [15:0] sum_new;
  logic [4:0]  shamt;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    if (cfg.pattern_count == 5'd0) begin
      n_eff = 5'd1;
    end else if (cfg.pattern_count > gccd_pkg::MaxPatterns) begin
      n_eff = gccd_pkg::MaxPatterns;
    end else begin
      n_eff = cfg.pattern_count;
    end
  end

  assign diff   = (first_q >= second_q) ? (first_q - second_q) : (second_q - first_q);
  assign bit_ge = first_q >= second_q;
  assign shamt  = n_eff - 5'd1 - pos_q;

  always_comb begin
    par_new = parity_q ^ bit_ge;
    pos_new = pos_q;
    sum_new = sum_q;
    if (pos_q < n_eff) begin
      if (par_new) begin
        sum_new = sum_q + (16'd1 << shamt[3:0]);
      end
      pos_new = pos_q + 5'd1;
    end
  end

  assign emit = (req_type_q == gccd_pkg::ReqPattern) && (pos_new >= n_eff);

  always_comb begin
    lit_mask_d = lit_mask_q;
    parity_d   = parity_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    if (fire) begin
      if (req_type_q == gccd_pkg::ReqReference) begin
        lit_mask_d = (diff >= cfg.contrast_threshold) | prior_q;
        parity_d   = 1'b0;
        pos_d      = 5'd0;
        sum_d      = 16'd0;
      end else if (emit) begin
        parity_d = 1'b0;
        pos_d    = 5'd0;
        sum_d    = 16'd0;
      end else begin
        parity_d = par_new;
        pos_d    = pos_new;
        sum_d    = sum_new;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = fire && emit;
    end
    col_d  = (sum_new > cfg.column_shift) ? (sum_new - cfg.column_shift) : 16'd0;
    cval_d = lit_mask_q && ({1'b0, col_d} < cfg.column_count);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lit_mask_q  <= 1'b0;
      parity_q    <= 1'b0;
      pos_q       <= 5'd0;
      sum_q       <= 16'd0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      lit_mask_q  <= lit_mask_d;
      parity_q    <= parity_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_type_q <= req_type_i;
      first_q    <= first_sample_i;
      second_q   <= second_sample_i;
      prior_q    <= prior_mask_i;
    end
    if (fire && emit) begin
      col_q  <= col_d;
      cval_q <= cval_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign decoded_column_o = col_q;
  assign column_valid_o   = cval_q;

endmodule

// File: dv/gray_code_column_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gray_code_column_decoder_tb
// Streams reference and Gray code sample pairs into the decoder under random
// valid/ready idling and register settings. Each column result is checked
// against a cycle-free decoder model that tracks mask, parity and column sum.
// ----------------------------------------------------------------------------
module gray_code_column_decoder_tb;

  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned LongHoldCycles = 200;
  localparam int unsigned SettleCycles   = 4;

  typedef struct packed {
    gccd_pkg::req_e kind;
    logic [7:0]     first;
    logic [7:0]     second;
    logic           prior;
  } sample_pair_t;

  typedef struct packed {
    logic [15:0] column;
    logic        valid;
  } column_result_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid_q = 1'b0;
  logic                           req_type_q = 1'b0;
  logic [7:0]                     first_q    = '0;
  logic [7:0]                     second_q   = '0;
  logic                           prior_q    = 1'b0;
  logic                           out_ready_q = 1'b0;
  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [gccd_pkg::AddrWidth-1:0] paddr   = '0;
  logic [gccd_pkg::DataWidth-1:0] pwdata  = '0;

  logic                           in_ready_o;
  logic                           out_valid_o;
  logic [15:0]                    decoded_column_o;
  logic                           column_valid_o;
  logic [gccd_pkg::DataWidth-1:0] prdata;
  logic                           pready;

  gray_code_column_decoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid_q),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_q),
    .first_sample_i   (first_q),
    .second_sample_i  (second_q),
    .prior_mask_i     (prior_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_q),
    .decoded_column_o (decoded_column_o),
    .column_valid_o   (column_valid_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // decoder model state and register copy
  gccd_pkg::cfg_t dec_cfg = '{gccd_pkg::ResetThreshold, gccd_pkg::ResetPatterns,
                              gccd_pkg::ResetShift, gccd_pkg::ResetColCount};
  logic        dec_mask   = 1'b0;
  logic        dec_parity = 1'b0;
  logic [4:0]  dec_pos    = '0;
  logic [15:0] dec_sum    = '0;

  sample_pair_t   pair_q[$];
  column_result_t column_q[$];
  sample_pair_t   tx_cur;
  int unsigned    tx_gap = 0;
  int unsigned    rx_hold = 0;
  int unsigned    rx_wait;
  int unsigned    mismatches = 0;
  int unsigned    quiet_cycles = 0;
  bit             tx_idle_on = 1'b1;
  bit             rx_idle_on = 1'b1;
  bit             rx_long_req = 1'b0;

  function automatic logic [4:0] patterns_in_use();
    if (dec_cfg.pattern_count == 5'd0) return 5'd1;
    if (dec_cfg.pattern_count > gccd_pkg::MaxPatterns) return gccd_pkg::MaxPatterns;
    return dec_cfg.pattern_count;
  endfunction

  function automatic void clear_pixel_state();
    dec_parity = 1'b0;
    dec_pos    = '0;
    dec_sum    = '0;
  endfunction

  function automatic void decode_pair(sample_pair_t p);
    logic [4:0]     n;
    logic [7:0]     diff;
    logic [15:0]    col;
    column_result_t r;
    n = patterns_in_use();
    if (p.kind == gccd_pkg::ReqReference) begin
      diff = (p.first >= p.second) ? p.first - p.second : p.second - p.first;
      dec_mask = (diff >= dec_cfg.contrast_threshold) || p.prior;
      clear_pixel_state();
      return;
    end
    dec_parity ^= (p.first >= p.second);
    if (dec_pos < n) begin
      if (dec_parity) dec_sum += 16'd1 << (n - 5'd1 - dec_pos);
      dec_pos++;
    end
    if (dec_pos < n) return;
    col = (dec_sum > dec_cfg.column_shift) ? dec_sum - dec_cfg.column_shift : '0;
    r.column = col;
    r.valid  = dec_mask && (dec_cfg.column_count != '0) &&
               ({1'b0, col} <= dec_cfg.column_count - 17'd1);
    column_q.push_back(r);
    clear_pixel_state();
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (!rst_n) begin
      in_valid_q <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid_q && in_ready_o) begin
        decode_pair(tx_cur);
        tx_gap = tx_idle_on ? $urandom_range(0, 6) : 0;
      end
      if (!in_valid_q || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_q <= 1'b0;
        end else if (pair_q.size() > 0) begin
          tx_cur = pair_q.pop_front();
          req_type_q <= tx_cur.kind;
          first_q    <= tx_cur.first;
          second_q   <= tx_cur.second;
          prior_q    <= tx_cur.prior;
          in_valid_q <= 1'b1;
        end else begin
          in_valid_q <= 1'b0;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk_i) begin
    if (!rst_n) begin
      out_ready_q <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid_o && out_ready_q) begin
        if (column_q.size() == 0) begin
          $display("%0t: unexpected result, column %0d valid %0b", $time,
                   decoded_column_o, column_valid_o);
          mismatches++;
        end else begin
          if (decoded_column_o !== column_q[0].column) begin
            $display("%0t: decoded_column expected %0d actual %0d", $time,
                     column_q[0].column, decoded_column_o);
            mismatches++;
          end
          if (column_valid_o !== column_q[0].valid) begin
            $display("%0t: column_valid expected %0b actual %0b", $time,
                     column_q[0].valid, column_valid_o);
            mismatches++;
          end
          void'(column_q.pop_front());
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_q <= 1'b0;
      end else if (rx_long_req) begin
        rx_long_req = 1'b0;
        rx_hold = LongHoldCycles - 1;
        out_ready_q <= 1'b0;
      end else if (out_valid_o && out_ready_q) begin
        rx_wait = rx_idle_on ? $urandom_range(0, 6) : 0;
        if (rx_wait > 0) begin
          rx_hold = rx_wait - 1;
          out_ready_q <= 1'b0;
        end else begin
          out_ready_q <= 1'b1;
        end
      end else begin
        out_ready_q <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid_q && in_ready_o) || (out_valid_o && out_ready_q) ||
          (psel && penable && pwrite && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic reg_write(input gccd_pkg::reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= gccd_pkg::AddrWidth'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      gccd_pkg::RegThreshold: dec_cfg.contrast_threshold = value[7:0];
      gccd_pkg::RegPatterns:  dec_cfg.pattern_count      = value[4:0];
      gccd_pkg::RegShift:     dec_cfg.column_shift       = value[15:0];
      gccd_pkg::RegColCount:  dec_cfg.column_count       = value[16:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pair_q.size() != 0 || in_valid_q || column_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic push_pair(input gccd_pkg::req_e kind, input int a, input int b,
                           input bit prior);
    sample_pair_t p;
    p.kind   = kind;
    p.first  = a[7:0];
    p.second = b[7:0];
    p.prior  = prior;
    pair_q.push_back(p);
  endtask

  task automatic push_reference();
    int a;
    int b;
    int d;
    a = $urandom_range(0, 255);
    b = $urandom_range(0, 255);
    if ($urandom_range(0, 2) == 0) begin
      d = int'(dec_cfg.contrast_threshold) + $urandom_range(0, 2) - 1;
      if (d < 0) d = 0;
      b = (a >= d) ? a - d : a + d;
      if (b > 255) b = 255;
    end
    push_pair(gccd_pkg::ReqReference, a, b, $urandom_range(0, 3) == 0);
  endtask

  task automatic push_bit(input bit value);
    int a;
    int b;
    if (value) begin
      a = $urandom_range(0, 255);
      b = $urandom_range(0, a);
    end else begin
      a = $urandom_range(0, 254);
      b = $urandom_range(a + 1, 255);
    end
    push_pair(gccd_pkg::ReqPattern, a, b, 1'($urandom_range(0, 1)));
  endtask

  // first k pairs of the Gray code of col over n patterns, msb first
  task automatic push_code_word(input int n, input int k, input int col);
    int gray;
    gray = col ^ (col >> 1);
    for (int i = 0; i < k; i++) push_bit(1'((gray >> (n - 1 - i)) & 1));
  endtask

  function automatic int pick_column(input int n);
    int limit;
    limit = (1 << n) - 1;
    case ($urandom_range(0, 4))
      0: return (int'(dec_cfg.column_shift) + int'(dec_cfg.column_count) - 1 +
                 $urandom_range(0, 2) - 1) & limit;
      1: return (int'(dec_cfg.column_shift) + $urandom_range(0, 2) - 1) & limit;
      2: return $urandom_range(0, 1) ? 0 : limit;
      default: return $urandom_range(0, limit);
    endcase
  endfunction

  // mostly complete pixels, some broken pixels and noise
  task automatic fill_phase(input int unsigned n_items);
    int unsigned count;
    int          n;
    int          k;
    count = 0;
    n = patterns_in_use();
    while (count < n_items) begin
      case ($urandom_range(0, 9))
        0: begin
          push_pair(gccd_pkg::req_e'($urandom_range(0, 1)), $urandom_range(0, 255),
                    $urandom_range(0, 255), 1'($urandom_range(0, 1)));
          count++;
        end
        1: begin
          k = $urandom_range(0, n - 1);
          push_reference();
          push_code_word(n, k, pick_column(n));
          count += 1 + k;
        end
        2: begin
          push_code_word(n, n, pick_column(n));
          count += n;
        end
        default: begin
          push_reference();
          push_code_word(n, n, pick_column(n));
          count += 1 + n;
        end
      endcase
    end
  endtask

  task automatic run_phase(input logic [7:0] thr, input logic [4:0] pats,
                           input logic [15:0] shift, input logic [16:0] count,
                           input int unsigned n_items, input bit tx_idle,
                           input bit rx_idle);
    reg_write(gccd_pkg::RegThreshold, 32'(thr));
    reg_write(gccd_pkg::RegPatterns, 32'(pats));
    reg_write(gccd_pkg::RegShift, 32'(shift));
    reg_write(gccd_pkg::RegColCount, 32'(count));
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    fill_phase(n_items);
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // reset settings: full-width column at the last valid index
    push_pair(gccd_pkg::ReqReference, 255, 0, 1'b0);
    push_code_word(10, 10, 1023);
    // low contrast rescued by prior mask, then abandoned by a new reference
    push_pair(gccd_pkg::ReqReference, 47, 16, 1'b1);
    push_pair(gccd_pkg::ReqPattern, 0, 255, 1'b0);
    push_pair(gccd_pkg::ReqPattern, 200, 200, 1'b1);
    push_pair(gccd_pkg::ReqReference, 0, 0, 1'b0);
    push_pair(gccd_pkg::ReqPattern, 255, 0, 1'b1);
    push_pair(gccd_pkg::ReqPattern, 0, 1, 1'b0);
    push_pair(gccd_pkg::ReqPattern, 128, 128, 1'b0);
    wait_idle();
    // count lowered below the pixel in progress
    reg_write(gccd_pkg::RegPatterns, 32'd2);
    push_pair(gccd_pkg::ReqPattern, 0, 255, 1'b0);
    wait_idle();
    // count of zero acts as one, column count of zero
    reg_write(gccd_pkg::RegPatterns, 32'd0);
    reg_write(gccd_pkg::RegColCount, 32'd0);
    push_pair(gccd_pkg::ReqReference, 0, 255, 1'b0);
    push_pair(gccd_pkg::ReqPattern, 255, 255, 1'b0);
    push_pair(gccd_pkg::ReqPattern, 3, 200, 1'b1);
    wait_idle();

    // long receiver stall with the sender pushing single-pair pixels
    reg_write(gccd_pkg::RegThreshold, 32'd0);
    reg_write(gccd_pkg::RegPatterns, 32'd1);
    reg_write(gccd_pkg::RegShift, 32'd0);
    reg_write(gccd_pkg::RegColCount, 32'd1);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    fill_phase(150);
    rx_long_req = 1'b1;
    wait_idle();
    // sender pause until drained, no register change
    tx_idle_on = 1'b1;
    fill_phase(40);
    wait_idle();

    run_phase(8'd255, 5'd16, 16'hFFFF, 17'h10000, 220, 1'b1, 1'b1);
    run_phase(8'($urandom_range(0, 255)), 5'd4, 16'd3, 17'd10, 200, 1'b1, 1'b0);
    run_phase(8'd128, 5'd31, 16'd0, 17'h1FFFF, 230, 1'b0, 1'b1);
    run_phase(8'd32, 5'd0, 16'd0, 17'd0, 120, 1'b1, 1'b1);
    run_phase(8'($urandom_range(0, 255)), 5'd8, 16'($urandom_range(0, 255)),
              17'($urandom_range(1, 256)), 200, 1'b1, 1'b1);
    run_phase(8'd1, 5'd3, 16'd1, 17'd5, 150, 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 5'd12, 16'($urandom_range(0, 4095)),
              17'($urandom_range(1, 4096)), 150, 1'b1, 1'b1);

    wait_idle();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && column_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/gccd_pkg.sv
rtl/core/gccd_cfg.sv
rtl/core/gray_code_column_decoder.sv
dv/gray_code_column_decoder_tb.sv
